### rtl/core/lts_pkg.sv
// Package for the labelled tensor store.
// Holds sizes, opcodes, status and register codes, and the structs shared
// between the address unit and the top level. No dependencies.
package lts_pkg;

  localparam int STORE_DEPTH = 4096;
  localparam int MAX_EXTENT  = 64;
  localparam int MAX_DIMS    = 3;
  localparam int NSLOT       = 3;

  localparam int ADDR_W   = $clog2(STORE_DEPTH);
  localparam int DATA_W   = 64;
  localparam int LABEL_W  = 8;
  localparam int CRD_W    = 6;
  localparam int EXT_W    = 7;
  localparam int DCNT_W   = 2;
  localparam int STRIDE_W = 13;
  localparam int IDX_W    = 20;
  localparam int CFG_W    = 8;
  localparam int CIDX_W   = 3;

  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_VEC   = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_UNMATCHED = 2'd1;
  localparam logic [1:0] ST_RANGE     = 2'd2;
  localparam logic [1:0] ST_BEYOND    = 2'd3;

  localparam logic [CIDX_W-1:0] REG_DIM_COUNT = 3'd0;
  localparam logic [CIDX_W-1:0] REG_LABEL_0   = 3'd1;
  localparam logic [CIDX_W-1:0] REG_LABEL_1   = 3'd2;
  localparam logic [CIDX_W-1:0] REG_LABEL_2   = 3'd3;
  localparam logic [CIDX_W-1:0] REG_EXTENT_0  = 3'd4;
  localparam logic [CIDX_W-1:0] REG_EXTENT_1  = 3'd5;
  localparam logic [CIDX_W-1:0] REG_EXTENT_2  = 3'd6;

  typedef struct packed {
    logic [DCNT_W-1:0]                 dim_count;
    logic [NSLOT-1:0][LABEL_W-1:0]     label;
    logic [NSLOT-1:0][EXT_W-1:0]       extent;
  } cfg_t;

  typedef struct packed {
    logic                valid;
    logic [1:0]          status;
    logic [ADDR_W-1:0]   base;
    logic [STRIDE_W-1:0] step;
    logic [EXT_W-1:0]    vlen;
  } loc_res_t;

endpackage

### rtl/core/lts_ram.sv
// Generic single-port synchronous RAM with registered read.
// Standalone; width and depth come from parameters.
module lts_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### rtl/core/lts_locate.sv
// Address unit: label matching, bound checks and mixed-radix index.
// Four register stages from go to res.valid. Uses lts_pkg.
module lts_locate import lts_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          go,
  input  logic                          vec,
  input  logic [NSLOT-1:0][LABEL_W-1:0] slot_label,
  input  logic [NSLOT-1:0][CRD_W-1:0]   slot_coord,
  input  cfg_t                          cfg,
  output loc_res_t                      res
);

  logic [DCNT_W-1:0]  n_used;
  logic [LABEL_W-1:0] last_lab;
  logic [NSLOT-1:0]   found;
  logic [1:0]         jsel [NSLOT];
  logic [NSLOT-1:0]   is_vec;
  logic [NSLOT-1:0]   vdim;
  logic [NSLOT-1:0]   zero_c;
  logic [NSLOT-1:0]   fail;
  logic [EXT_W-1:0]   ext_eff [NSLOT];
  logic [CRD_W-1:0]   c0 [NSLOT];
  logic               err0;
  logic [1:0]         st0;

  // stage 1
  logic               s1_valid, s1_err;
  logic [1:0]         s1_st;
  logic [CRD_W-1:0]   s1_c [NSLOT];
  logic [EXT_W-1:0]   s1_ext [NSLOT];
  logic [NSLOT-1:0]   s1_vd;
  // stage 2
  logic                s2_valid, s2_err;
  logic [1:0]          s2_st;
  logic [CRD_W-1:0]    s2_c0, s2_c2;
  logic [EXT_W-1:0]    s2_ext [NSLOT];
  logic [NSLOT-1:0]    s2_vd;
  logic [STRIDE_W-1:0] s2_stride2;
  logic [STRIDE_W-1:0] s2_p1;
  // stage 3
  logic                s3_valid, s3_err;
  logic [1:0]          s3_st;
  logic [CRD_W-1:0]    s3_p0;
  logic [STRIDE_W-1:0] s3_p1;
  logic [IDX_W-1:0]    s3_p2;
  logic [IDX_W-1:0]    s3_span;
  logic [STRIDE_W-1:0] s3_step;
  logic [EXT_W-1:0]    s3_vlen;

  logic [STRIDE_W-1:0] step3;
  logic [EXT_W-1:0]    vlen3;
  logic [IDX_W-1:0]    idx4;
  logic [IDX_W-1:0]    end4;

  always_comb begin
    n_used = (cfg.dim_count == '0) ? DCNT_W'(1) :
             (cfg.dim_count > DCNT_W'(MAX_DIMS)) ? DCNT_W'(MAX_DIMS) : cfg.dim_count;
    last_lab = slot_label[n_used - DCNT_W'(1)];
    for (int i = 0; i < NSLOT; i++) begin
      found[i] = 1'b0;
      jsel[i]  = 2'd0;
      for (int j = NSLOT - 1; j >= 0; j--) begin
        if ((j < int'(n_used)) && (slot_label[j] == cfg.label[i])) begin
          found[i] = 1'b1;
          jsel[i]  = 2'(j);
        end
      end
      if (cfg.extent[i] == '0) begin
        ext_eff[i] = EXT_W'(1);
      end else if (cfg.extent[i] > EXT_W'(MAX_EXTENT)) begin
        ext_eff[i] = EXT_W'(MAX_EXTENT);
      end else begin
        ext_eff[i] = cfg.extent[i];
      end
      is_vec[i] = vec && (i < int'(n_used)) && found[i] &&
                  (slot_label[jsel[i]] == last_lab);
    end
    for (int i = 0; i < NSLOT; i++) begin
      vdim[i] = is_vec[i];
      for (int k = 0; k < i; k++) begin
        if (is_vec[k]) vdim[i] = 1'b0;
      end
      zero_c[i] = vdim[i] || (vec && (jsel[i] == n_used - DCNT_W'(1)));
      fail[i]   = (i < int'(n_used)) &&
                  (!found[i] ||
                   (!zero_c[i] && ({1'b0, slot_coord[jsel[i]]} >= ext_eff[i])));
      c0[i]     = ((i < int'(n_used)) && !zero_c[i]) ? slot_coord[jsel[i]] : '0;
    end
    err0 = 1'b0;
    st0  = ST_OK;
    for (int i = NSLOT - 1; i >= 0; i--) begin
      if (fail[i]) begin
        err0 = 1'b1;
        st0  = found[i] ? ST_RANGE : ST_UNMATCHED;
      end
    end
    if (!err0 && vec && (vdim == '0)) begin
      err0 = 1'b1;
      st0  = ST_UNMATCHED;
    end
  end

  always_comb begin
    step3 = STRIDE_W'(1);
    vlen3 = EXT_W'(1);
    if (s2_vd[0]) begin
      vlen3 = s2_ext[0];
    end else if (s2_vd[1]) begin
      step3 = STRIDE_W'(s2_ext[0]);
      vlen3 = s2_ext[1];
    end else if (s2_vd[2]) begin
      step3 = s2_stride2;
      vlen3 = s2_ext[2];
    end
    idx4 = IDX_W'(s3_p0) + IDX_W'(s3_p1) + s3_p2;
    end4 = idx4 + s3_span;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      res.valid <= 1'b0;
    end else begin
      s1_valid  <= go;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      res.valid <= s3_valid;
    end
    s1_err <= err0;
    s1_st  <= st0;
    s1_vd  <= vdim;
    for (int i = 0; i < NSLOT; i++) begin
      s1_c[i]   <= c0[i];
      s1_ext[i] <= ext_eff[i];
      s2_ext[i] <= s1_ext[i];
    end
    s2_err     <= s1_err;
    s2_st      <= s1_st;
    s2_vd      <= s1_vd;
    s2_c0      <= s1_c[0];
    s2_c2      <= s1_c[2];
    s2_stride2 <= STRIDE_W'(s1_ext[0]) * STRIDE_W'(s1_ext[1]);
    s2_p1      <= STRIDE_W'(s1_c[1]) * STRIDE_W'(s1_ext[0]);
    s3_err     <= s2_err;
    s3_st      <= s2_st;
    s3_p0      <= s2_c0;
    s3_p1      <= s2_p1;
    s3_p2      <= IDX_W'(s2_c2) * IDX_W'(s2_stride2);
    s3_span    <= IDX_W'(vlen3 - EXT_W'(1)) * IDX_W'(step3);
    s3_step    <= step3;
    s3_vlen    <= vlen3;
    res.base   <= idx4[ADDR_W-1:0];
    res.step   <= s3_step;
    res.vlen   <= s3_vlen;
    if (s3_err) begin
      res.status <= s3_st;
    end else if (end4 >= IDX_W'(STORE_DEPTH)) begin
      res.status <= ST_BEYOND;
    end else begin
      res.status <= ST_OK;
    end
  end

endmodule

### rtl/core/labelled_tensor_store.sv
// Labelled tensor store: 64-bit words addressed by labelled coordinates.
// Top level; uses lts_pkg, lts_locate and lts_ram.
//
// An item is taken when start is high and busy is low; every item gives its
// results on done, one per cycle, the final one with last set, and the
// receiver cannot stall them. Element reads and writes, and any error, give
// a single result after the four-stage address unit and, for a read, the
// registered read of the store. A vector read of L classes gives L results,
// one store read per cycle. A clear sweeps the 4096-word store at one word
// per cycle and then gives its result. After reset the same clearing pass
// runs with busy high and gives no result; configuration writes are taken
// at any time.
module labelled_tensor_store import lts_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         opcode,
  input  logic [LABEL_W-1:0] dim_a_label,
  input  logic [CRD_W-1:0]   dim_a_coord,
  input  logic [LABEL_W-1:0] dim_b_label,
  input  logic [CRD_W-1:0]   dim_b_coord,
  input  logic [LABEL_W-1:0] dim_c_label,
  input  logic [CRD_W-1:0]   dim_c_coord,
  input  logic [DATA_W-1:0]  write_value,
  input  logic               cfg_write,
  input  logic [CIDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]   cfg_data,
  output logic               done,
  output logic [DATA_W-1:0]  read_value,
  output logic [CRD_W-1:0]   position,
  output logic [1:0]         status,
  output logic               last
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOC  = 2'd1;
  localparam logic [1:0] S_CLR  = 2'd2;
  localparam logic [1:0] S_VEC  = 2'd3;

  logic [1:0]          state;
  logic [1:0]          op;
  logic [DATA_W-1:0]   wval;
  logic                clr_emit;
  logic [ADDR_W-1:0]   clr_addr;
  logic [ADDR_W-1:0]   addr;
  logic [STRIDE_W-1:0] step;
  logic [EXT_W-1:0]    cnt;
  logic [EXT_W-1:0]    vlen;
  logic                rd_pend;
  logic [CRD_W-1:0]    pend_pos;
  logic                pend_last;
  logic                accept;
  logic                vec_last;
  cfg_t                cfg;
  loc_res_t            loc;

  logic                ram_we;
  logic [ADDR_W-1:0]   ram_addr;
  logic [DATA_W-1:0]   ram_wdata;
  logic [DATA_W-1:0]   ram_rdata;

  assign busy     = (state != S_IDLE) || rd_pend;
  assign accept   = start && !busy;
  assign vec_last = (EXT_W'(cnt + EXT_W'(1)) == vlen);

  lts_locate u_locate (
    .clk        (clk),
    .rst        (rst),
    .go         (accept && (opcode != OP_CLEAR)),
    .vec        (opcode == OP_VEC),
    .slot_label ({dim_c_label, dim_b_label, dim_a_label}),
    .slot_coord ({dim_c_coord, dim_b_coord, dim_a_coord}),
    .cfg        (cfg),
    .res        (loc)
  );

  lts_ram #(.WIDTH(DATA_W), .DEPTH(STORE_DEPTH)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = addr;
    ram_wdata = wval;
    case (state)
      S_CLR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_addr;
        ram_wdata = '0;
      end
      S_LOC: begin
        ram_addr = loc.base;
        ram_we   = loc.valid && (loc.status == ST_OK) && (op == OP_WRITE);
      end
      default: begin
        ram_addr = addr;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dim_count <= DCNT_W'(1);
      cfg.label[0]  <= LABEL_W'(0);
      cfg.label[1]  <= LABEL_W'(1);
      cfg.label[2]  <= LABEL_W'(2);
      cfg.extent[0] <= EXT_W'(1);
      cfg.extent[1] <= EXT_W'(1);
      cfg.extent[2] <= EXT_W'(1);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_DIM_COUNT: cfg.dim_count <= cfg_data[DCNT_W-1:0];
        REG_LABEL_0:   cfg.label[0]  <= cfg_data[LABEL_W-1:0];
        REG_LABEL_1:   cfg.label[1]  <= cfg_data[LABEL_W-1:0];
        REG_LABEL_2:   cfg.label[2]  <= cfg_data[LABEL_W-1:0];
        REG_EXTENT_0:  cfg.extent[0] <= cfg_data[EXT_W-1:0];
        REG_EXTENT_1:  cfg.extent[1] <= cfg_data[EXT_W-1:0];
        REG_EXTENT_2:  cfg.extent[2] <= cfg_data[EXT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLR;
      clr_addr <= '0;
      clr_emit <= 1'b0;
      rd_pend  <= 1'b0;
      done     <= 1'b0;
    end else begin
      done    <= 1'b0;
      rd_pend <= 1'b0;
      if (rd_pend) begin
        done       <= 1'b1;
        read_value <= ram_rdata;
        position   <= pend_pos;
        status     <= ST_OK;
        last       <= pend_last;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            op   <= opcode;
            wval <= write_value;
            if (opcode == OP_CLEAR) begin
              state    <= S_CLR;
              clr_addr <= '0;
              clr_emit <= 1'b1;
            end else begin
              state <= S_LOC;
            end
          end
        end
        S_LOC: begin
          if (loc.valid) begin
            addr <= loc.base;
            step <= loc.step;
            vlen <= loc.vlen;
            cnt  <= '0;
            if ((loc.status != ST_OK) || (op == OP_WRITE)) begin
              state      <= S_IDLE;
              done       <= 1'b1;
              read_value <= '0;
              position   <= '0;
              status     <= loc.status;
              last       <= 1'b1;
            end else if (op == OP_READ) begin
              state     <= S_IDLE;
              rd_pend   <= 1'b1;
              pend_pos  <= '0;
              pend_last <= 1'b1;
            end else begin
              state <= S_VEC;
            end
          end
        end
        S_VEC: begin
          rd_pend   <= 1'b1;
          pend_pos  <= cnt[CRD_W-1:0];
          pend_last <= vec_last;
          addr      <= ADDR_W'(addr + ADDR_W'(step));
          cnt       <= EXT_W'(cnt + EXT_W'(1));
          if (vec_last) begin
            state <= S_IDLE;
          end
        end
        S_CLR: begin
          if (clr_addr == ADDR_W'(STORE_DEPTH - 1)) begin
            state <= S_IDLE;
            if (clr_emit) begin
              done       <= 1'b1;
              read_value <= '0;
              position   <= '0;
              status     <= ST_OK;
              last       <= 1'b1;
            end
          end else begin
            clr_addr <= ADDR_W'(clr_addr + ADDR_W'(1));
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/core/lts_checker.sv
// Port-level checks for the labelled tensor store, bound to the top level.
// Uses lts_pkg; attached by the bind at the end of this file.
module lts_checker import lts_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              done,
  input logic [DATA_W-1:0] read_value,
  input logic [CRD_W-1:0]  position,
  input logic [1:0]        status,
  input logic              last
);

  a_take_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy low right after an item was taken");

  a_vec_burst: assert property (@(posedge clk) disable iff (rst)
    done && !last |=> done)
    else $error("vector results not back to back");

  a_vec_pos: assert property (@(posedge clk) disable iff (rst)
    done && !last |=> position == CRD_W'($past(position) + CRD_W'(1)))
    else $error("vector position did not advance by one");

  a_err_single: assert property (@(posedge clk) disable iff (rst)
    done && (status != ST_OK) |-> last && (read_value == '0) && (position == '0))
    else $error("error result not a single zero item");

  a_mid_ok: assert property (@(posedge clk) disable iff (rst)
    done && !last |-> status == ST_OK)
    else $error("non-final result carries an error");

endmodule

bind labelled_tensor_store lts_checker u_lts_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .done       (done),
  .read_value (read_value),
  .position   (position),
  .status     (status),
  .last       (last)
);

### tb/sv/tb.sv
// Testbench for labelled_tensor_store: directed table, then random items
// under several register settings, each result checked against a predictor or a fixed expected value.
// Depends on lts_pkg and the labelled_tensor_store RTL.
`timescale 1ns / 100ps

module tb;
  import lts_pkg::*;

  localparam int CYCLE_LIMIT = 5000000;
  localparam int ITEMS_PER_PHASE = 48;
  localparam int NPHASE = 6;

  typedef struct packed {
    logic [1:0]               op;
    logic [2:0][LABEL_W-1:0]  lab;
    logic [2:0][CRD_W-1:0]    crd;
    logic [DATA_W-1:0]        wval;
  } item_t;

  typedef struct packed {
    logic [DATA_W-1:0] val;
    logic [CRD_W-1:0]  pos;
    logic [1:0]        st;
    logic              lst;
  } res_t;

  typedef struct packed {
    logic [DCNT_W-1:0]        dims;
    logic [2:0][LABEL_W-1:0]  labels;
    logic [2:0][EXT_W-1:0]    extents;
  } setting_t;

  typedef struct packed {
    logic [3:0] sel;
    item_t      it;
    logic       typed;
    res_t       want;
  } row_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               start;
  logic               busy;
  logic [1:0]         opcode;
  logic [LABEL_W-1:0] dim_a_label, dim_b_label, dim_c_label;
  logic [CRD_W-1:0]   dim_a_coord, dim_b_coord, dim_c_coord;
  logic [DATA_W-1:0]  write_value;
  logic               cfg_write;
  logic [CIDX_W-1:0]  cfg_index;
  logic [CFG_W-1:0]   cfg_data;
  logic               done;
  logic [DATA_W-1:0]  read_value;
  logic [CRD_W-1:0]   position;
  logic [1:0]         status;
  logic               last;

  labelled_tensor_store dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .opcode(opcode),
    .dim_a_label(dim_a_label), .dim_a_coord(dim_a_coord),
    .dim_b_label(dim_b_label), .dim_b_coord(dim_b_coord),
    .dim_c_label(dim_c_label), .dim_c_coord(dim_c_coord),
    .write_value(write_value), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .done(done), .read_value(read_value),
    .position(position), .status(status), .last(last)
  );

  always #1 clk = ~clk;

  logic [DATA_W-1:0]  mirror_words [STORE_DEPTH];
  logic [DCNT_W-1:0]  cur_dims;
  logic [LABEL_W-1:0] cur_label [3];
  logic [EXT_W-1:0]   cur_extent [3];
  res_t               calc [MAX_EXTENT];
  res_t               results_due [$];
  row_t               dir_rows [$];
  setting_t           settings [8];
  int                 errors = 0;
  int                 cycles = 0;
  res_t               w;

  function automatic res_t mk_res(logic [63:0] v, int p, logic [1:0] s, bit l);
    res_t r;
    r.val = v;
    r.pos = CRD_W'(p);
    r.st  = s;
    r.lst = l;
    return r;
  endfunction

  function automatic item_t mk_item(logic [1:0] op, int la, int ca, int lb, int cb,
                                    int lc, int cc, logic [63:0] v);
    item_t it;
    it.op = op;
    it.lab[0] = LABEL_W'(la); it.crd[0] = CRD_W'(ca);
    it.lab[1] = LABEL_W'(lb); it.crd[1] = CRD_W'(cb);
    it.lab[2] = LABEL_W'(lc); it.crd[2] = CRD_W'(cc);
    it.wval = v;
    return it;
  endfunction

  function automatic setting_t mk_setting(int d, int l0, int l1, int l2,
                                          int e0, int e1, int e2);
    setting_t s;
    s.dims = DCNT_W'(d);
    s.labels[0] = LABEL_W'(l0); s.labels[1] = LABEL_W'(l1); s.labels[2] = LABEL_W'(l2);
    s.extents[0] = EXT_W'(e0); s.extents[1] = EXT_W'(e1); s.extents[2] = EXT_W'(e2);
    return s;
  endfunction

  function automatic int dims_used();
    return (cur_dims == 0) ? 1 : int'(cur_dims);
  endfunction

  function automatic int eff_extent(int i);
    int e;
    e = cur_extent[i];
    if (e == 0) e = 1;
    if (e > MAX_EXTENT) e = MAX_EXTENT;
    return e;
  endfunction

  // Bind each dimension to its first matching slot and build the linear index.
  task automatic locate_word(input item_t it, input bit vec, output logic [1:0] st,
                             output int base, output int step, output int vlen);
    int n, ext, c, stride, idx, i, j, k;
    bit have_vec;
    n = dims_used();
    stride = 1; idx = 0; c = 0; have_vec = 0;
    step = 1; vlen = 1; st = ST_OK;
    for (i = 0; i < n; i++) begin
      if (st == ST_OK) begin
        ext = eff_extent(i);
        j = n;
        for (k = n - 1; k >= 0; k--) if (it.lab[k] == cur_label[i]) j = k;
        if (j == n) begin
          st = ST_UNMATCHED;
        end else if (vec && !have_vec && it.lab[j] == it.lab[n-1]) begin
          have_vec = 1; step = stride; vlen = ext; c = 0;
        end else if (vec && j == n - 1) begin
          c = 0;
        end else begin
          c = it.crd[j];
          if (c >= ext) st = ST_RANGE;
        end
        idx += c * stride;
        stride *= ext;
      end
    end
    if (st == ST_OK) begin
      if (vec && !have_vec) st = ST_UNMATCHED;
      else if (vec && idx + (vlen - 1) * step >= STORE_DEPTH) st = ST_BEYOND;
      else if (!vec && idx >= STORE_DEPTH) st = ST_BEYOND;
    end
    base = idx;
  endtask

  task automatic serve_access(input item_t it, output int cnt);
    int base, step, vlen, k;
    logic [1:0] st;
    cnt = 1;
    calc[0] = mk_res(64'd0, 0, ST_OK, 1'b1);
    if (it.op == OP_CLEAR) begin
      for (k = 0; k < STORE_DEPTH; k++) mirror_words[k] = '0;
    end else begin
      locate_word(it, it.op == OP_VEC, st, base, step, vlen);
      if (st != ST_OK) begin
        calc[0] = mk_res(64'd0, 0, st, 1'b1);
      end else if (it.op == OP_READ) begin
        calc[0] = mk_res(mirror_words[base], 0, ST_OK, 1'b1);
      end else if (it.op == OP_WRITE) begin
        mirror_words[base] = it.wval;
      end else begin
        cnt = vlen;
        for (k = 0; k < vlen; k++)
          calc[k] = mk_res(mirror_words[base + k * step], k, ST_OK, k == vlen - 1);
      end
    end
  endtask

  task automatic queue_result(input res_t r);
    results_due = {results_due, r};
  endtask

  task automatic issue(input item_t it, input bit typed, input res_t want);
    int cnt, k;
    @(negedge clk);
    start <= 1'b1;
    opcode <= it.op;
    dim_a_label <= it.lab[0]; dim_a_coord <= it.crd[0];
    dim_b_label <= it.lab[1]; dim_b_coord <= it.crd[1];
    dim_c_label <= it.lab[2]; dim_c_coord <= it.crd[2];
    write_value <= it.wval;
    @(posedge clk);
    while (busy) @(posedge clk);
    serve_access(it, cnt);
    if (typed) queue_result(want);
    else for (k = 0; k < cnt; k++) queue_result(calc[k]);
  endtask

  task automatic idle_gap(int pct);
    int n;
    if ($urandom_range(0, 99) < pct) begin
      n = $urandom_range(1, 6);
      @(negedge clk);
      start <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic cfg_put(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] d);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    case (idx)
      REG_DIM_COUNT: cur_dims = d[DCNT_W-1:0];
      REG_LABEL_0:   cur_label[0] = d;
      REG_LABEL_1:   cur_label[1] = d;
      REG_LABEL_2:   cur_label[2] = d;
      REG_EXTENT_0:  cur_extent[0] = d[EXT_W-1:0];
      REG_EXTENT_1:  cur_extent[1] = d[EXT_W-1:0];
      REG_EXTENT_2:  cur_extent[2] = d[EXT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic load_setting(setting_t s);
    @(negedge clk);
    start <= 1'b0;
    @(posedge clk);
    while (busy || results_due.size() != 0) @(posedge clk);
    cfg_put(REG_DIM_COUNT, CFG_W'(s.dims));
    cfg_put(REG_LABEL_0, s.labels[0]);
    cfg_put(REG_LABEL_1, s.labels[1]);
    cfg_put(REG_LABEL_2, s.labels[2]);
    cfg_put(REG_EXTENT_0, CFG_W'(s.extents[0]));
    cfg_put(REG_EXTENT_1, CFG_W'(s.extents[1]));
    cfg_put(REG_EXTENT_2, CFG_W'(s.extents[2]));
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // Mostly well-formed accesses: configured labels in shuffled slots,
  // coordinates inside the extents, with some noise and stray coordinates.
  task automatic draw_item(input item_t prev_write, input bit have_write,
                           output item_t it);
    int n, r, k, pick, tmp;
    int order [3];
    r = $urandom_range(0, 99);
    it.op = (r < 2) ? OP_CLEAR : (r < 40) ? OP_WRITE : (r < 70) ? OP_READ : OP_VEC;
    it.wval = {$urandom, $urandom};
    for (k = 0; k < 3; k++) begin
      it.lab[k] = LABEL_W'($urandom_range(0, 255));
      it.crd[k] = CRD_W'($urandom_range(0, 63));
    end
    if ($urandom_range(0, 99) < 85) begin
      n = dims_used();
      for (k = 0; k < 3; k++) order[k] = k;
      for (k = n - 1; k > 0; k--) begin
        pick = $urandom_range(0, k);
        tmp = order[k]; order[k] = order[pick]; order[pick] = tmp;
      end
      for (k = 0; k < n; k++) begin
        it.lab[k] = cur_label[order[k]];
        it.crd[k] = CRD_W'($urandom_range(0, eff_extent(order[k]) - 1));
      end
      if ($urandom_range(0, 9) == 0)
        it.crd[$urandom_range(0, n - 1)] = CRD_W'($urandom_range(0, 63));
    end
    if (it.op == OP_READ && have_write && $urandom_range(0, 2) == 0) begin
      it = prev_write;
      it.op = OP_READ;
    end
  endtask

  task automatic add_row(int sel, item_t it, bit typed, res_t want);
    row_t r;
    r.sel = 4'(sel);
    r.it = it;
    r.typed = typed;
    r.want = want;
    dir_rows = {dir_rows, r};
  endtask

  always @(posedge clk) begin
    cycles = cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && done) begin
      if (results_due.size() == 0) begin
        $error("unexpected result: read_value %h position %0d status %0d last %0d",
               read_value, position, status, last);
        errors++;
      end else begin
        w = results_due.pop_front();
        if (read_value !== w.val) begin
          $error("read_value: expected %h, got %h", w.val, read_value);
          errors++;
        end
        if (position !== w.pos) begin
          $error("position: expected %0d, got %0d", w.pos, position);
          errors++;
        end
        if (status !== w.st) begin
          $error("status: expected %0d, got %0d", w.st, status);
          errors++;
        end
        if (last !== w.lst) begin
          $error("last: expected %0d, got %0d", w.lst, last);
          errors++;
        end
      end
    end
  end

  initial begin
    int k, p, cnt;
    int idle_pct [NPHASE];
    int phase_sel [NPHASE];
    item_t it, prev_write;
    bit have_write;
    res_t none;
    row_t r;

    rst = 1'b1; start = 1'b0; opcode = OP_READ;
    dim_a_label = '0; dim_a_coord = '0; dim_b_label = '0; dim_b_coord = '0;
    dim_c_label = '0; dim_c_coord = '0; write_value = '0;
    cfg_write = 1'b0; cfg_index = REG_DIM_COUNT; cfg_data = '0;
    cur_dims = 2'd1;
    for (k = 0; k < 3; k++) begin
      cur_label[k] = LABEL_W'(k);
      cur_extent[k] = EXT_W'(1);
    end
    for (k = 0; k < STORE_DEPTH; k++) mirror_words[k] = '0;
    none = '0;
    have_write = 0;
    prev_write = '0;

    settings[0] = mk_setting(1, 0, 1, 2, 1, 1, 1);
    settings[1] = mk_setting(3, 10, 20, 30, 4, 5, 6);
    settings[2] = mk_setting(3, 7, 7, 9, 2, 3, 4);
    settings[3] = mk_setting(3, 255, 0, 128, 64, 64, 64);
    settings[4] = mk_setting(0, 42, 1, 2, 0, 0, 0);
    settings[5] = mk_setting(2, 3, 250, 4, 127, 64, 1);
    settings[6] = mk_setting(1, 200, 0, 0, 64, 1, 1);
    settings[7] = mk_setting(2, 8, 16, 24, 3, 7, 5);

    // reset registers: one dimension, label 0, one class
    add_row(0, mk_item(OP_READ, 0, 0, 0, 0, 0, 0, 64'd0), 1, mk_res(0, 0, ST_OK, 1));
    add_row(0, mk_item(OP_WRITE, 0, 0, 9, 9, 9, 9, '1), 1, mk_res(0, 0, ST_OK, 1));
    add_row(0, mk_item(OP_READ, 0, 0, 0, 0, 0, 0, 64'd0), 1, mk_res('1, 0, ST_OK, 1));
    add_row(0, mk_item(OP_READ, 5, 0, 0, 0, 0, 0, 64'd0), 1,
            mk_res(0, 0, ST_UNMATCHED, 1));
    add_row(0, mk_item(OP_READ, 0, 63, 0, 0, 0, 0, 64'd0), 1, mk_res(0, 0, ST_RANGE, 1));
    add_row(0, mk_item(OP_VEC, 0, 7, 1, 0, 2, 0, 64'd0), 0, none);
    // three dimensions named in shuffled order
    add_row(1, mk_item(OP_WRITE, 30, 5, 20, 4, 10, 3, 64'h0123456789abcdef), 0, none);
    add_row(0, mk_item(OP_READ, 10, 3, 30, 5, 20, 4, 64'd0), 0, none);
    add_row(0, mk_item(OP_VEC, 20, 4, 30, 5, 10, 0, 64'd0), 0, none);
    add_row(0, mk_item(OP_VEC, 10, 3, 20, 4, 30, 63, 64'd0), 0, none);
    add_row(0, mk_item(OP_READ, 10, 0, 20, 5, 30, 0, 64'd0), 1, mk_res(0, 0, ST_RANGE, 1));
    add_row(0, mk_item(OP_READ, 11, 0, 20, 63, 30, 0, 64'd0), 1,
            mk_res(0, 0, ST_UNMATCHED, 1));
    add_row(0, mk_item(OP_READ, 10, 63, 20, 0, 31, 0, 64'd0), 1,
            mk_res(0, 0, ST_RANGE, 1));
    // duplicate configured labels
    add_row(2, mk_item(OP_VEC, 9, 3, 1, 0, 7, 0, 64'd0), 0, none);
    add_row(0, mk_item(OP_VEC, 7, 0, 9, 0, 5, 0, 64'd0), 1,
            mk_res(0, 0, ST_UNMATCHED, 1));
    add_row(0, mk_item(OP_WRITE, 7, 1, 9, 2, 3, 0, 64'hfedcba9876543210), 0, none);
    // full extents, store boundary
    add_row(3, mk_item(OP_WRITE, 255, 63, 0, 63, 128, 0, 64'h8000000000000001), 0, none);
    add_row(0, mk_item(OP_READ, 0, 63, 128, 0, 255, 63, 64'd0), 0, none);
    add_row(0, mk_item(OP_READ, 255, 0, 0, 0, 128, 1, 64'd0), 1,
            mk_res(0, 0, ST_BEYOND, 1));
    add_row(0, mk_item(OP_VEC, 255, 0, 0, 0, 128, 0, 64'd0), 1,
            mk_res(0, 0, ST_BEYOND, 1));
    add_row(0, mk_item(OP_VEC, 128, 0, 0, 63, 255, 0, 64'd0), 0, none);
    add_row(0, mk_item(OP_CLEAR, 0, 0, 0, 0, 0, 0, 64'd0), 1, mk_res(0, 0, ST_OK, 1));
    add_row(0, mk_item(OP_READ, 255, 63, 0, 63, 128, 0, 64'd0), 1,
            mk_res(0, 0, ST_OK, 1));
    // zero dimension count and zero extents
    add_row(4, mk_item(OP_READ, 42, 0, 0, 0, 0, 0, 64'd0), 1, mk_res(0, 0, ST_OK, 1));
    add_row(0, mk_item(OP_READ, 42, 1, 0, 0, 0, 0, 64'd0), 1, mk_res(0, 0, ST_RANGE, 1));
    add_row(0, mk_item(OP_VEC, 42, 33, 0, 0, 0, 0, 64'd0), 0, none);

    phase_sel = '{3, 5, 7, 1, 6, 0};
    idle_pct  = '{0, 65, 0, 17, 65, 17};

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (k = 0; k < dir_rows.size(); k++) begin
      r = dir_rows[k];
      if (r.sel != 0) load_setting(settings[r.sel]);
      issue(r.it, r.typed, r.want);
    end

    for (p = 0; p < NPHASE; p++) begin
      if (phase_sel[p] == 0)
        load_setting(mk_setting($urandom_range(1, 3), $urandom_range(0, 255),
                                $urandom_range(0, 255), $urandom_range(0, 255),
                                $urandom_range(1, 8), $urandom_range(1, 64),
                                $urandom_range(1, 8)));
      else
        load_setting(settings[phase_sel[p]]);
      have_write = 0;
      for (cnt = 0; cnt < ITEMS_PER_PHASE; cnt++) begin
        draw_item(prev_write, have_write, it);
        issue(it, 1'b0, none);
        if (it.op == OP_WRITE) begin
          prev_write = it;
          have_write = 1;
        end
        idle_gap(idle_pct[p]);
      end
    end

    @(negedge clk);
    start <= 1'b0;
    @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end

endmodule
